>>> rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared definitions for the Lamport sequence clock
// Operation codes, status codes, register indexes, field widths and the
// watermark check used by the clock datapath.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int LOCAL_W = 56;
    localparam int STAMP_W = 64;
    localparam int COUNT_W = 64;
    localparam int NODE_W  = 8;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    // Result tdata: 617 bits of fields padded to 78 bytes.
    localparam int M_DATA_W = 624;
    localparam int S_DATA_W = 64;

    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd0;
    localparam logic [OP_W-1:0] OP_COMMIT  = 3'd1;
    localparam logic [OP_W-1:0] OP_ABORT   = 3'd2;
    localparam logic [OP_W-1:0] OP_OBSERVE = 3'd3;
    localparam logic [OP_W-1:0] OP_SWEEP   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_SKIP    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADNODE = 3'd2;
    localparam logic [STAT_W-1:0] ST_REJECT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PANIC   = 3'd4;
    localparam logic [STAT_W-1:0] ST_WARN    = 3'd5;

    localparam logic [1:0] REG_NODE   = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_WARN   = 2'd2;
    localparam logic [1:0] REG_PANIC  = 2'd3;

    localparam logic [NODE_W-1:0]  NODE_MAX_VALID = 8'd127;
    localparam logic [NODE_W-1:0]  NODE_RESET     = 8'd255;
    localparam logic [LOCAL_W-1:0] LOCAL_TOP      = {LOCAL_W{1'b1}};
    localparam logic [LOCAL_W-1:0] WARN_RESET     = 56'h04_0000_0000_0000;
    localparam logic [LOCAL_W-1:0] PANIC_RESET    = 56'h80_0000_0000_0000;

    // Panic takes precedence over warning.
    function automatic logic [STAT_W-1:0] level_check(
        input logic [LOCAL_W-1:0] v,
        input logic [LOCAL_W-1:0] warn,
        input logic [LOCAL_W-1:0] panic
    );
        logic [STAT_W-1:0] st;
        if (v >= panic) begin
            st = ST_PANIC;
        end else if (v >= warn) begin
            st = ST_WARN;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

>>> rtl/lamport_sequence_clock.sv
// ----------------------------------------------------------------------------
// lamport_sequence_clock: 56-bit Lamport logical clock with node stamping
// Advance, commit/abort advance, observe of a remote stamp and sweep, with
// warning and panic watermarks and wrapping statistics counters.
// ----------------------------------------------------------------------------
// Latency: the result of a transaction appears on the master side in the cycle
// after it is accepted. Throughput: one transaction per cycle while results
// are taken, set by the single registered pass through the clock update logic;
// the output register frees itself in the same cycle that its result is taken.
// Reset (aresetn low, synchronous) clears the clock and all counters and
// loads the configuration registers with their reset values.
module lamport_sequence_clock (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: remote_stamp [63:0]
    input  logic [lsc_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: op [2:0]
    input  logic [lsc_pkg::OP_W-1:0]       s_tuser,
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata from bit 0 up: stamp_out [63:0], current_stamp [127:64],
    // observe_raised [128], sweep_batch [184:129], advance_total [248:185],
    // commit_total [312:249], abort_total [376:313], raise_total [440:377],
    // remote_max [496:441], sweep_total [560:497], batch_max [616:561],
    // zero padding [623:617]
    output logic [lsc_pkg::M_DATA_W-1:0]   m_tdata,
    // tuser: status [2:0]
    output logic [lsc_pkg::STAT_W-1:0]     m_tuser,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lsc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lsc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lsc_pkg::*;

    // Configuration registers
    logic [NODE_W-1:0]  node_reg;
    logic               enable_reg;
    logic [LOCAL_W-1:0] warn_reg;
    logic [LOCAL_W-1:0] panic_reg;

    // Clock state
    logic [LOCAL_W-1:0] local_clock_reg,      local_clock_next;
    logic [COUNT_W-1:0] advance_count_reg,    advance_count_next;
    logic [COUNT_W-1:0] commit_count_reg,     commit_count_next;
    logic [COUNT_W-1:0] abort_count_reg,      abort_count_next;
    logic [COUNT_W-1:0] raise_count_reg,      raise_count_next;
    logic [LOCAL_W-1:0] remote_seen_max_reg,  remote_seen_max_next;
    logic [COUNT_W-1:0] sweep_count_reg,      sweep_count_next;
    logic [LOCAL_W-1:0] last_sweep_clock_reg, last_sweep_clock_next;
    logic [LOCAL_W-1:0] largest_batch_reg,    largest_batch_next;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]   m_tuser_reg, m_tuser_next;

    logic in_take;
    logic cfg_write;

    // Per-transaction intermediate values
    logic               node_ok;
    logic [LOCAL_W-1:0] clock_inc;
    logic [LOCAL_W-1:0] remote_value;
    logic [LOCAL_W-1:0] raise_target;
    logic [LOCAL_W-1:0] sweep_diff;
    logic [STAMP_W-1:0] stamp_out;
    logic [STAMP_W-1:0] current_stamp;
    logic [STAT_W-1:0]  status;
    logic [STAT_W-1:0]  level;
    logic               raised;
    logic [LOCAL_W-1:0] sweep_batch;

    // The output register accepts a new result whenever it is empty or its
    // current result is being taken in this cycle, so a stalled result never
    // costs more than the cycles it is stalled.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;

    // Node ids from 0 to 127 are valid; the upper half of the byte is not.
    assign node_ok      = (node_reg <= NODE_MAX_VALID);
    assign clock_inc    = local_clock_reg + LOCAL_W'(1);
    assign remote_value = s_tdata[LOCAL_W-1:0];
    assign raise_target = remote_value + LOCAL_W'(1);
    assign sweep_diff   = local_clock_reg - last_sweep_clock_reg;

    always_comb begin
        local_clock_next      = local_clock_reg;
        advance_count_next    = advance_count_reg;
        commit_count_next     = commit_count_reg;
        abort_count_next      = abort_count_reg;
        raise_count_next      = raise_count_reg;
        remote_seen_max_next  = remote_seen_max_reg;
        sweep_count_next      = sweep_count_reg;
        last_sweep_clock_next = last_sweep_clock_reg;
        largest_batch_next    = largest_batch_reg;
        stamp_out             = '0;
        status                = ST_OK;
        raised                = 1'b0;
        sweep_batch           = '0;
        level                 = ST_OK;

        unique case (s_tuser)
            OP_ADVANCE: begin
                if (!node_ok) begin
                    status = ST_BADNODE;
                end else begin
                    local_clock_next   = clock_inc;
                    advance_count_next = advance_count_reg + COUNT_W'(1);
                    stamp_out          = {node_reg, clock_inc};
                end
            end
            OP_COMMIT, OP_ABORT: begin
                if (!enable_reg || !node_ok) begin
                    status = ST_SKIP;
                end else begin
                    local_clock_next   = clock_inc;
                    advance_count_next = advance_count_reg + COUNT_W'(1);
                    stamp_out          = {node_reg, clock_inc};
                    if (s_tuser == OP_COMMIT) begin
                        commit_count_next = commit_count_reg + COUNT_W'(1);
                    end else begin
                        abort_count_next = abort_count_reg + COUNT_W'(1);
                    end
                end
            end
            OP_OBSERVE: begin
                // A zero stamp carries no information and is ignored. A remote
                // value at the very top of the range cannot be followed and is
                // rejected. Otherwise, if the clock is not already past the remote value, it
                // moves past it, unless that would land it at or above the panic level, in
                // which case nothing at all changes.
                if (s_tdata != '0) begin
                    if (remote_value == LOCAL_TOP) begin
                        status = ST_REJECT;
                    end else begin
                        if (local_clock_reg <= remote_value) begin
                            level  = level_check(raise_target, warn_reg, panic_reg);
                            status = level;
                            if (level != ST_PANIC) begin
                                local_clock_next   = raise_target;
                                raise_count_next   = raise_count_reg + COUNT_W'(1);
                                advance_count_next = advance_count_reg + COUNT_W'(1);
                                raised             = 1'b1;
                            end
                        end
                        if (level != ST_PANIC && remote_value > remote_seen_max_reg) begin
                            remote_seen_max_next = remote_value;
                        end
                    end
                end
            end
            OP_SWEEP: begin
                if (!enable_reg) begin
                    status = ST_SKIP;
                end else begin
                    level  = level_check(local_clock_reg, warn_reg, panic_reg);
                    status = level;
                    if (level != ST_PANIC) begin
                        // After the clock has wrapped below the last sweep
                        // point the batch counts as empty.
                        if (local_clock_reg >= last_sweep_clock_reg) begin
                            sweep_batch = sweep_diff;
                        end
                        last_sweep_clock_next = local_clock_reg;
                        sweep_count_next      = sweep_count_reg + COUNT_W'(1);
                        if (sweep_batch > largest_batch_reg) begin
                            largest_batch_next = sweep_batch;
                        end
                    end
                end
            end
            default: begin
                status = ST_SKIP;
            end
        endcase

        // Stamp of the clock after this op; zero for a bad node or a zero clock.
        if (node_ok && local_clock_next != '0) begin
            current_stamp = {node_reg, local_clock_next};
        end else begin
            current_stamp = '0;
        end

        m_tdata_next = {
            {(M_DATA_W - 617){1'b0}},
            largest_batch_next,
            sweep_count_next,
            remote_seen_max_next,
            raise_count_next,
            abort_count_next,
            commit_count_next,
            advance_count_next,
            sweep_batch,
            raised,
            current_stamp,
            stamp_out
        };
        m_tuser_next = status;
    end

    // Clock state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_clock_reg      <= '0;
            advance_count_reg    <= '0;
            commit_count_reg     <= '0;
            abort_count_reg      <= '0;
            raise_count_reg      <= '0;
            remote_seen_max_reg  <= '0;
            sweep_count_reg      <= '0;
            last_sweep_clock_reg <= '0;
            largest_batch_reg    <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            if (in_take) begin
                local_clock_reg      <= local_clock_next;
                advance_count_reg    <= advance_count_next;
                commit_count_reg     <= commit_count_next;
                abort_count_reg      <= abort_count_next;
                raise_count_reg      <= raise_count_next;
                remote_seen_max_reg  <= remote_seen_max_next;
                sweep_count_reg      <= sweep_count_next;
                last_sweep_clock_reg <= last_sweep_clock_next;
                largest_batch_reg    <= largest_batch_next;
                m_tvalid_reg         <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // Configuration registers: each sits at a 64-bit slot, so address bits
    // 4 and 3 select the register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg   <= NODE_RESET;
            enable_reg <= 1'b0;
            warn_reg   <= WARN_RESET;
            panic_reg  <= PANIC_RESET;
        end else if (cfg_write) begin
            unique case (paddr[4:3])
                REG_NODE:   node_reg   <= pwdata[NODE_W-1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_WARN:   warn_reg   <= pwdata[LOCAL_W-1:0];
                REG_PANIC:  panic_reg  <= pwdata[LOCAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_NODE:   prdata = CFG_DATA_W'(node_reg);
            REG_ENABLE: prdata = CFG_DATA_W'(enable_reg);
            REG_WARN:   prdata = CFG_DATA_W'(warn_reg);
            REG_PANIC:  prdata = CFG_DATA_W'(panic_reg);
            default:    prdata = '0;
        endcase
    end

endmodule
